/* rtl/eacu_pkg.sv */
`default_nettype none

package eacu_pkg;

    localparam int CLIENT_W   = 5;
    localparam int INDEX_W    = 10;
    localparam int DATA_W     = 32;
    localparam int GAIN_W     = 25;
    localparam int COUNT_W    = 5;
    localparam int GAIN_N_W   = GAIN_W + COUNT_W;
    localparam int FRAC_W     = 24;
    localparam int ACC_W      = 64;

    // Fixed field widths wide enough for the largest vector length and client count
    localparam int VIDX_W     = 16;
    localparam int SLOT_W     = 24;

    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [1:0] REG_UPDATE_MODE    = 2'd0;
    localparam logic [1:0] REG_STEP_GAIN      = 2'd1;
    localparam logic [1:0] REG_ACTIVE_CLIENTS = 2'd2;

    typedef enum logic {
        MODE_VAR_REDUCED = 1'b0,
        MODE_PLAIN       = 1'b1
    } t_mode;

    typedef struct packed {
        logic [CLIENT_W-1:0] client;
        logic [INDEX_W-1:0]  index;
        logic [DATA_W-1:0]   weight;
        logic                last;
        logic [VIDX_W-1:0]   vidx;
        logic [SLOT_W-1:0]   slot;
        logic                in_range;
        logic                writer;
    } t_item;

    typedef struct packed {
        t_mode                mode;
        logic [GAIN_W-1:0]    gain;
        logic [GAIN_N_W-1:0]  gain_n;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

`default_nettype wire

/* rtl/eacu_front.sv */
`default_nettype none

module eacu_front
    import eacu_pkg::*;
#(
    parameter int VECTOR_LENGTH = 1024,
    parameter int MAX_CLIENTS   = 16
) (
    input  wire logic                start,
    input  wire logic [CLIENT_W-1:0] i_client_id,
    input  wire logic [INDEX_W-1:0]  i_element_index,
    input  wire logic [DATA_W-1:0]   i_weight_value,
    input  wire logic                i_vector_end,
    input  wire t_queue_status       i_q_status,
    input  wire logic                i_clearing,
    output logic                     o_busy,
    output logic                     o_push,
    output t_item                    o_item
);

    logic                in_range;
    logic                client_ok;
    logic [CLIENT_W-1:0] client_m1;

    assign in_range  = 32'(i_element_index) < 32'(VECTOR_LENGTH);
    assign client_ok = (i_client_id != '0) && (32'(i_client_id) <= 32'(MAX_CLIENTS));
    assign client_m1 = i_client_id - CLIENT_W'(1);

    assign o_busy = i_clearing || i_q_status.full;
    assign o_push = start && !o_busy;

    always_comb begin
        o_item.client   = i_client_id;
        o_item.index    = i_element_index;
        o_item.weight   = i_weight_value;
        o_item.last     = i_vector_end;
        o_item.vidx     = VIDX_W'(i_element_index);
        // flat slot of this client's buffered element
        o_item.slot     = SLOT_W'(32'(client_m1) * 32'(VECTOR_LENGTH)
                                  + 32'(i_element_index));
        o_item.in_range = in_range;
        o_item.writer   = in_range && client_ok;
    end

endmodule

`default_nettype wire

/* rtl/eacu_queue.sv */
`default_nettype none

module eacu_queue
    import eacu_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    input  wire logic  i_pop,
    output t_item      o_head,
    output t_queue_status o_status
);

    t_item              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_PTR_W:0]   r_count;
    logic [Q_PTR_W:0]   n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + (Q_PTR_W+1)'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - (Q_PTR_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = r_count == (Q_PTR_W+1)'(Q_DEPTH);
    assign o_status.empty = r_count == '0;

endmodule

`default_nettype wire

/* rtl/eacu_back.sv */
`default_nettype none

module eacu_back
    import eacu_pkg::*;
#(
    parameter int VECTOR_LENGTH = 1024,
    parameter int MAX_CLIENTS   = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cfg                i_cfg,
    input  wire t_item               i_head,
    input  wire t_queue_status       i_q_status,
    output logic                     o_pop,
    output logic                     o_clearing,
    output logic                     o_done,
    output logic [INDEX_W-1:0]       o_center_index,
    output logic signed [DATA_W-1:0] o_center_value,
    output logic                     o_reply_end,
    output logic [CLIENT_W-1:0]      o_reply_client
);

    localparam int V_AW     = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;
    localparam int C_DEPTH  = MAX_CLIENTS * VECTOR_LENGTH;
    localparam int C_AW     = (C_DEPTH > 1) ? $clog2(C_DEPTH) : 1;
    localparam int CLR_W    = $clog2(C_DEPTH + 1);
    localparam logic [CLR_W-1:0]  CLR_LAST = CLR_W'(C_DEPTH - 1);
    localparam logic [DATA_W-1:0] SAT_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN  = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] ONE_Q    = DATA_W'(1) << FRAC_W;
    localparam logic [ACC_W-1:0]  HALF_LSB = ACC_W'(1) << (FRAC_W - 1);
    localparam int Q_W      = ACC_W - FRAC_W;

    function automatic logic [DATA_W-1:0] sat_sum(input logic [DATA_W+1:0] v);
        logic [2:0] top;
        top = v[DATA_W+1:DATA_W-1];
        if (top == 3'b000 || top == 3'b111) begin
            return v[DATA_W-1:0];
        end
        return v[DATA_W+1] ? SAT_MIN : SAT_MAX;
    endfunction

    function automatic logic [DATA_W-1:0] sat_q(input logic [Q_W-1:0] v);
        logic [Q_W-DATA_W:0] top;
        top = v[Q_W-1:DATA_W-1];
        if (top == '0 || top == '1) begin
            return v[DATA_W-1:0];
        end
        return v[Q_W-1] ? SAT_MIN : SAT_MAX;
    endfunction

    // Stores
    logic [DATA_W-1:0] r_client_mem [C_DEPTH];
    logic [DATA_W-1:0] r_sum_mem    [VECTOR_LENGTH];
    logic [DATA_W-1:0] r_center_mem [VECTOR_LENGTH];

    // Clearing pass
    logic             r_clearing;
    logic [CLR_W-1:0] r_clr_cnt;
    logic             clr_in_vec;

    // Pipeline
    logic  r_s1_v, r_s2_v, r_s3_v, r_s4_v;
    t_item r_s1, r_s2, r_s3, r_s4;

    logic [DATA_W-1:0]        r_b_rd, r_s_rd, r_z_rd;
    logic signed [DATA_W:0]   r_s2_d;
    logic [DATA_W-1:0]        r_s2_s_old, r_s2_s_new, r_s2_z;
    logic signed [ACC_W-1:0]  r_s3_pz, r_s3_pd, r_s3_ps;
    logic [DATA_W-1:0]        r_s3_z;
    logic signed [ACC_W-1:0]  r_s4_acc;
    logic [DATA_W-1:0]        r_s4_z;

    logic                     r_done;
    logic [INDEX_W-1:0]       r_out_index;
    logic [DATA_W-1:0]        r_out_value;
    logic                     r_out_end;
    logic [CLIENT_W-1:0]      r_out_client;

    logic                     hazard;
    logic signed [DATA_W:0]   s1_d;
    logic [DATA_W+1:0]        s1_sum;
    logic [DATA_W-1:0]        s1_s_new;
    logic signed [DATA_W-1:0] s2_coef;
    logic signed [DATA_W-1:0] s2_z;
    logic signed [GAIN_N_W:0] s2_gn;
    logic signed [GAIN_W:0]   s2_g;
    logic signed [DATA_W-1:0] s2_sel;
    logic signed [ACC_W-1:0]  s2_pz, s2_pd, s2_ps;
    logic signed [ACC_W-1:0]  s3_acc;
    logic [ACC_W-1:0]         s4_rnd;
    logic [DATA_W-1:0]        s4_result;

    logic                     cmem_we, smem_we, zmem_we;
    logic [C_AW-1:0]          cmem_waddr;
    logic [V_AW-1:0]          smem_waddr, zmem_waddr;
    logic [DATA_W-1:0]        cmem_wdata, smem_wdata, zmem_wdata;

    // Hold the head while an earlier item for the same element has not written back
    assign hazard = i_head.in_range && (
        (r_s1_v && r_s1.writer && r_s1.vidx == i_head.vidx) ||
        (r_s2_v && r_s2.writer && r_s2.vidx == i_head.vidx) ||
        (r_s3_v && r_s3.writer && r_s3.vidx == i_head.vidx) ||
        (r_s4_v && r_s4.writer && r_s4.vidx == i_head.vidx));

    assign o_pop      = !i_q_status.empty && !r_clearing && !hazard;
    assign o_clearing = r_clearing;
    assign clr_in_vec = 32'(r_clr_cnt) < 32'(VECTOR_LENGTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clearing) begin
            if (r_clr_cnt == CLR_LAST) begin
                r_clearing <= 1'b0;
            end else begin
                r_clr_cnt <= r_clr_cnt + CLR_W'(1);
            end
        end
    end

    // Stage 1: new sum and difference to the buffered element
    assign s1_d     = $signed({r_s1.weight[DATA_W-1], r_s1.weight})
                    - $signed({r_b_rd[DATA_W-1], r_b_rd});
    assign s1_sum   = {{2{r_s_rd[DATA_W-1]}}, r_s_rd} + {s1_d[DATA_W], s1_d};
    assign s1_s_new = sat_sum(s1_sum);

    // Stage 2: products
    assign s2_coef = $signed(ONE_Q - DATA_W'(i_cfg.gain_n));
    assign s2_z    = $signed(r_s2_z);
    assign s2_gn   = $signed({1'b0, i_cfg.gain_n});
    assign s2_g    = $signed({1'b0, i_cfg.gain});

    always_comb begin
        case (i_cfg.mode)
            MODE_PLAIN: begin
                s2_sel = $signed(r_s2_s_new);
                s2_pd  = '0;
            end
            default: begin
                s2_sel = $signed(r_s2_s_old);
                s2_pd  = s2_gn * r_s2_d;
            end
        endcase
    end

    assign s2_pz = s2_coef * s2_z;
    assign s2_ps = s2_g * s2_sel;

    // Stage 3: exact sum
    assign s3_acc = r_s3_pz + r_s3_pd + r_s3_ps;

    // Stage 4: round half up, saturate
    assign s4_rnd    = r_s4_acc + HALF_LSB;
    assign s4_result = !r_s4.in_range ? '0 :
                       (r_s4.writer ? sat_q(s4_rnd[ACC_W-1:FRAC_W]) : r_s4_z);

    // Store write ports, shared with the clearing pass
    assign cmem_we    = r_clearing || (r_s1_v && r_s1.writer);
    assign cmem_waddr = r_clearing ? r_clr_cnt[C_AW-1:0] : r_s1.slot[C_AW-1:0];
    assign cmem_wdata = r_clearing ? '0 : r_s1.weight;

    assign smem_we    = (r_clearing && clr_in_vec) || (r_s1_v && r_s1.writer);
    assign smem_waddr = r_clearing ? r_clr_cnt[V_AW-1:0] : r_s1.vidx[V_AW-1:0];
    assign smem_wdata = r_clearing ? '0 : s1_s_new;

    assign zmem_we    = (r_clearing && clr_in_vec) || (r_s4_v && r_s4.writer);
    assign zmem_waddr = r_clearing ? r_clr_cnt[V_AW-1:0] : r_s4.vidx[V_AW-1:0];
    assign zmem_wdata = r_clearing ? '0 : s4_result;

    always_ff @(posedge i_clk) begin
        if (cmem_we) begin
            r_client_mem[cmem_waddr] <= cmem_wdata;
        end
        if (o_pop && i_head.writer) begin
            r_b_rd <= r_client_mem[i_head.slot[C_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (smem_we) begin
            r_sum_mem[smem_waddr] <= smem_wdata;
        end
        if (o_pop && i_head.in_range) begin
            r_s_rd <= r_sum_mem[i_head.vidx[V_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (zmem_we) begin
            r_center_mem[zmem_waddr] <= zmem_wdata;
        end
        if (o_pop && i_head.in_range) begin
            r_z_rd <= r_center_mem[i_head.vidx[V_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_s1_v <= o_pop;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_done <= r_s4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1 <= i_head;
        end
        r_s2       <= r_s1;
        r_s2_d     <= s1_d;
        r_s2_s_old <= r_s_rd;
        r_s2_s_new <= s1_s_new;
        r_s2_z     <= r_z_rd;

        r_s3       <= r_s2;
        r_s3_pz    <= s2_pz;
        r_s3_pd    <= s2_pd;
        r_s3_ps    <= s2_ps;
        r_s3_z     <= r_s2_z;

        r_s4       <= r_s3;
        r_s4_acc   <= s3_acc;
        r_s4_z     <= r_s3_z;

        r_out_index  <= r_s4.index;
        r_out_value  <= s4_result;
        r_out_end    <= r_s4.last;
        r_out_client <= r_s4.client;
    end

    assign o_done         = r_done;
    assign o_center_index = r_out_index;
    assign o_center_value = $signed(r_out_value);
    assign o_reply_end    = r_out_end;
    assign o_reply_client = r_out_client;

endmodule

`default_nettype wire

/* rtl/elastic_average_center_update.sv */
`default_nettype none

// Parameter-server center update for elastic averaging SGD, one vector element per item.
// Input channel: an item (client, element index, Q8.24 weight, end mark) is taken on a
// clock edge where start is high and busy is low. Items may come every cycle while busy is low.
// Result channel: o_done is high for one cycle with the new center element, its index,
// the end mark and the client to reply to. Exactly one result per item, in order.
// The receiver cannot stall; results are simply presented for one cycle.
// An accepted item passes through the queue, the pipeline stages and the output register
// on its way to o_done. Throughput: one item per cycle unless the head is held. An item whose
// element index matches one of up to four items still in the multiply/accumulate pipe waits
// until that item writes its center and sum back; a four-entry queue absorbs this, and busy
// rises only when the queue is full or while the stores are being cleared.
// Configuration: APB registers update_mode (0x0), step_gain (0x4), active_clients (0x8);
// write them only while no item is in flight.
// Reset: after reset the client, sum and center stores are zeroed one entry per cycle;
// busy stays high meanwhile.

module elastic_average_center_update
    import eacu_pkg::*;
#(
    parameter int VECTOR_LENGTH = 1024,
    parameter int MAX_CLIENTS   = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,

    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [CLIENT_W-1:0]     i_client_id,
    input  wire logic [INDEX_W-1:0]      i_element_index,
    input  wire logic signed [DATA_W-1:0] i_weight_value,
    input  wire logic                    i_vector_end,

    output logic                         o_done,
    output logic [INDEX_W-1:0]           o_center_index,
    output logic signed [DATA_W-1:0]     o_center_value,
    output logic                         o_reply_end,
    output logic [CLIENT_W-1:0]          o_reply_client,

    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [CFG_ADDR_W-1:0]   paddr,
    input  wire logic [CFG_DATA_W-1:0]   pwdata,
    output logic [CFG_DATA_W-1:0]        prdata,
    output logic                         pready
);

    t_mode               r_update_mode;
    logic [GAIN_W-1:0]   r_step_gain;
    logic [COUNT_W-1:0]  r_active_clients;
    logic [GAIN_N_W-1:0] r_gain_n;
    logic                cfg_wr;
    t_cfg                cfg;

    logic          push;
    logic          pop;
    logic          clearing;
    t_item         front_item;
    t_item         head;
    t_queue_status q_status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_update_mode    <= MODE_VAR_REDUCED;
            r_step_gain      <= '0;
            r_active_clients <= COUNT_W'(1);
        end else if (cfg_wr) begin
            case (paddr[CFG_ADDR_W-1:2])
                REG_UPDATE_MODE:    r_update_mode    <= t_mode'(pwdata[0]);
                REG_STEP_GAIN:      r_step_gain      <= pwdata[GAIN_W-1:0];
                REG_ACTIVE_CLIENTS: r_active_clients <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Gain times client count, settled long before any item reaches the multipliers
    always_ff @(posedge i_clk) begin
        r_gain_n <= r_step_gain * r_active_clients;
    end

    always_comb begin
        prdata = '0;
        case (paddr[CFG_ADDR_W-1:2])
            REG_UPDATE_MODE:    prdata = CFG_DATA_W'(r_update_mode);
            REG_STEP_GAIN:      prdata = CFG_DATA_W'(r_step_gain);
            REG_ACTIVE_CLIENTS: prdata = CFG_DATA_W'(r_active_clients);
            default:            prdata = '0;
        endcase
    end

    assign cfg.mode   = r_update_mode;
    assign cfg.gain   = r_step_gain;
    assign cfg.gain_n = r_gain_n;

    eacu_front #(
        .VECTOR_LENGTH (VECTOR_LENGTH),
        .MAX_CLIENTS   (MAX_CLIENTS)
    ) u_front (
        .start           (start),
        .i_client_id     (i_client_id),
        .i_element_index (i_element_index),
        .i_weight_value  (i_weight_value),
        .i_vector_end    (i_vector_end),
        .i_q_status      (q_status),
        .i_clearing      (clearing),
        .o_busy          (busy),
        .o_push          (push),
        .o_item          (front_item)
    );

    eacu_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (front_item),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    eacu_back #(
        .VECTOR_LENGTH (VECTOR_LENGTH),
        .MAX_CLIENTS   (MAX_CLIENTS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_head         (head),
        .i_q_status     (q_status),
        .o_pop          (pop),
        .o_clearing     (clearing),
        .o_done         (o_done),
        .o_center_index (o_center_index),
        .o_center_value (o_center_value),
        .o_reply_end    (o_reply_end),
        .o_reply_client (o_reply_client)
    );

    a_no_result_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !o_done)
        else $error("result strobe during store clearing");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_status.full)
        else $error("item pushed into full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_status.empty)
        else $error("item popped from empty queue");

    a_result_follows_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> ##5 o_done)
        else $error("issued item produced no result");

endmodule

`default_nettype wire
